FILE: rtl/bhpq_pkg.sv
// Shared types and constants for the binary heap priority queue.
`default_nettype none
package bhpq_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 7;

    localparam logic       OP_INSERT = 1'b0;
    localparam logic       OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic              opcode;
        logic [KEY_W-1:0]  key_value;
    } req_t;

    typedef struct packed {
        logic [KEY_W-1:0]   removed_key;
        logic [KEY_W-1:0]   top_key;
        logic               top_valid;
        logic [COUNT_W-1:0] entry_count;
        logic [1:0]         status;
    } rsp_t;

    // True when a sits strictly above b under the given order
    function automatic logic above(input logic mode, input logic [KEY_W-1:0] a,
                                   input logic [KEY_W-1:0] b);
        logic signed [KEY_W-1:0] sa;
        logic signed [KEY_W-1:0] sb;
        sa = a;
        sb = b;
        return mode ? (sa < sb) : (sa > sb);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/bhpq_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
`default_nettype none
interface bhpq_req_if;
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic signed [31:0]     key_value;
    modport source (output valid, opcode, key_value, input ready);
    modport sink   (input valid, opcode, key_value, output ready);
endinterface

interface bhpq_rsp_if;
    logic                   valid;
    logic                   ready;
    logic signed [31:0]     removed_key;
    logic signed [31:0]     top_key;
    logic                   top_valid;
    logic [6:0]             entry_count;
    logic [1:0]             status;
    modport source (output valid, removed_key, top_key, top_valid, entry_count, status,
                    input ready);
    modport sink   (input valid, removed_key, top_key, top_valid, entry_count, status,
                    output ready);
endinterface

interface bhpq_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/bhpq_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/bhpq_fifo.sv
// Two-entry request queue between the front end and the heap engine.
`default_nettype none
module bhpq_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire bhpq_pkg::req_t push_data,
    output logic               full,
    input  wire logic          pop,
    output bhpq_pkg::req_t     pop_data,
    output logic               not_empty
);
    import bhpq_pkg::*;

    req_t       slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = slot_reg[rptr_reg];

    // Store payload
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop && not_empty)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push && !full} - {1'b0, pop && not_empty};
        end
    end
endmodule
`default_nettype wire

FILE: rtl/bhpq_engine.sv
// Heap engine: sift up on insert, sift down on remove, one level per pass.
`default_nettype none
module bhpq_engine #(
    parameter int DEPTH = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           mode,
    input  wire logic           req_valid,
    input  wire bhpq_pkg::req_t req_data,
    output logic                req_pop,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output bhpq_pkg::rsp_t      rsp_data
);
    import bhpq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1) + 1;   // 1-based slot, room for 2*pos+1

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_UPRD  = 4'd1;
    localparam logic [3:0] S_UPCMP = 4'd2;
    localparam logic [3:0] S_RTRD  = 4'd3;
    localparam logic [3:0] S_LSTRD = 4'd4;
    localparam logic [3:0] S_DNL   = 4'd5;
    localparam logic [3:0] S_DNR   = 4'd6;
    localparam logic [3:0] S_DNCMP = 4'd7;
    localparam logic [3:0] S_TOPRD = 4'd8;
    localparam logic [3:0] S_TOPW  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [PW-1:0]    cnt_reg, cnt_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [KEY_W-1:0] key_reg, key_next;      // key being sifted
    logic [KEY_W-1:0] lch_reg, lch_next;      // left child
    logic [KEY_W-1:0] top_reg, top_next;
    logic [KEY_W-1:0] rem_reg, rem_next;
    logic [1:0]       st_reg, st_next;
    logic             outv_reg, outv_next;

    logic             we;
    logic [PW-1:0]    wslot, rslot;
    logic [KEY_W-1:0] wdata, rdata;
    logic [PW-1:0]    lslot, rslot_c, parent;
    logic             has_r, pick_r, move;
    logic [KEY_W-1:0] best;

    bhpq_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (AW'(wslot - 1'b1)),
        .wdata (wdata),
        .raddr (AW'(rslot - 1'b1)),
        .rdata (rdata)
    );

    assign parent  = pos_reg >> 1;
    assign lslot   = {pos_reg[PW-2:0], 1'b0};
    assign rslot_c = {pos_reg[PW-2:0], 1'b1};
    assign has_r   = (rslot_c <= cnt_reg);
    // rdata holds right child in S_DNCMP; right wins unless left strictly better
    assign pick_r  = has_r && !above(mode, lch_reg, rdata);
    assign best    = pick_r ? rdata : lch_reg;
    assign move    = above(mode, lch_reg, key_reg) || (has_r && above(mode, rdata, key_reg));

    assign req_pop   = (state_reg == S_IDLE) && req_valid && !outv_reg;
    assign rsp_valid = outv_reg;
    assign rsp_data  = '{removed_key: rem_reg,
                         top_key:     (cnt_reg != '0) ? top_reg : '0,
                         top_valid:   (cnt_reg != '0),
                         entry_count: COUNT_W'(cnt_reg),
                         status:      st_reg};

    // Sequence one request through the heap
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        lch_next   = lch_reg;
        top_next   = top_reg;
        rem_next   = rem_reg;
        st_next    = st_reg;
        outv_next  = outv_reg;
        we         = 1'b0;
        wslot      = pos_reg;
        wdata      = key_reg;
        rslot      = parent;
        if (outv_reg && rsp_ready)
        begin
            outv_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && !outv_reg)
                begin
                    rem_next = '0;
                    st_next  = ST_DONE;
                    key_next = req_data.key_value;
                    if (req_data.opcode == OP_INSERT)
                    begin
                        if (cnt_reg >= PW'(DEPTH))
                        begin
                            st_next    = ST_FULL;
                            state_next = S_TOPRD;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg + 1'b1;
                            pos_next   = cnt_reg + 1'b1;
                            state_next = S_UPRD;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        st_next    = ST_EMPTY;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_RTRD;
                    end
                end
            end
            S_UPRD:
            begin
                // Read parent, or place at root
                if (pos_reg <= PW'(1))
                begin
                    we         = 1'b1;
                    state_next = S_TOPRD;
                end
                else
                begin
                    rslot      = parent;
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                we = 1'b1;
                if (above(mode, key_reg, rdata))
                begin
                    wdata      = rdata;
                    pos_next   = parent;
                    state_next = S_UPRD;
                end
                else
                begin
                    state_next = S_TOPRD;
                end
            end
            S_RTRD:
            begin
                rslot      = PW'(1);
                state_next = S_LSTRD;
            end
            S_LSTRD:
            begin
                // Capture old root, fetch last entry
                rem_next   = rdata;
                rslot      = cnt_reg;
                state_next = S_DNL;
            end
            S_DNL:
            begin
                if (state_reg == S_DNL && pos_reg == '0)
                begin
                    key_next = rdata;
                end
                rslot = lslot;
                if (pos_reg == '0)
                begin
                    // First pass: last entry just arrived
                    cnt_next = cnt_reg - 1'b1;
                    pos_next = PW'(1);
                    rslot    = PW'(2);
                    if (cnt_reg - 1'b1 < PW'(2))
                    begin
                        state_next = (cnt_reg - 1'b1 == '0) ? S_OUT : S_TOPW;
                    end
                    else
                    begin
                        state_next = S_DNR;
                    end
                end
                else if (lslot > cnt_reg)
                begin
                    state_next = S_TOPW;
                end
                else
                begin
                    state_next = S_DNR;
                end
            end
            S_DNR:
            begin
                lch_next   = rdata;
                rslot      = rslot_c;
                state_next = S_DNCMP;
            end
            S_DNCMP:
            begin
                if (move)
                begin
                    we         = 1'b1;
                    wdata      = best;
                    pos_next   = pick_r ? rslot_c : lslot;
                    state_next = S_DNL;
                end
                else
                begin
                    state_next = S_TOPW;
                end
            end
            S_TOPW:
            begin
                we         = 1'b1;
                state_next = S_TOPRD;
            end
            S_TOPRD:
            begin
                rslot      = PW'(1);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (st_next != ST_EMPTY && st_reg != ST_EMPTY)
                begin
                    top_next = rdata;
                end
                outv_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold pos at zero on entry to the sift-down so S_DNL knows its first pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            outv_reg  <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            outv_reg  <= outv_next;
            pos_reg   <= (state_reg == S_RTRD) ? '0 : pos_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        lch_reg <= lch_next;
        top_reg <= top_next;
        rem_reg <= rem_next;
        st_reg  <= st_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= PW'(DEPTH)) else $error("count beyond depth");
    a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        outv_reg && !rsp_ready |=> outv_reg) else $error("result dropped");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_pop |-> !outv_reg) else $error("request taken with result pending");
endmodule
`default_nettype wire

FILE: rtl/binary_heap_priority_queue.sv
// Top level: request queue, mode register and heap engine.
// Throughput: one request at a time through the engine, bound by the single RAM read
// port; the next starts once the result is taken. The front queue holds two requests
// while the engine works.
// Reset clears the count, queue and mode; heap storage is not cleared.
`default_nettype none
module binary_heap_priority_queue #(
    parameter int DEPTH = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bhpq_req_if.sink   req,
    bhpq_rsp_if.source rsp,
    bhpq_cfg_if.sink   cfg
);
    import bhpq_pkg::*;

    logic  mode_reg;
    logic  q_full, q_ne, q_pop;
    req_t  q_in, q_out;
    rsp_t  r;

    assign req.ready = !q_full;
    assign cfg.ready = 1'b1;
    assign q_in      = '{opcode: req.opcode, key_value: req.key_value};

    // Store order mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            mode_reg <= cfg.data;
        end
    end

    bhpq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req.valid),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_ne)
    );

    bhpq_engine #(.DEPTH(DEPTH)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .req_valid (q_ne),
        .req_data  (q_out),
        .req_pop   (q_pop),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (r)
    );

    assign rsp.removed_key = r.removed_key;
    assign rsp.top_key     = r.top_key;
    assign rsp.top_valid   = r.top_valid;
    assign rsp.entry_count = r.entry_count;
    assign rsp.status      = r.status;
endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the binary heap priority queue.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import bhpq_pkg::*;

    localparam int DEPTH      = 64;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic              opcode;
        logic signed [31:0] key_value;
        logic              check_fixed;
        logic signed [31:0] removed_key;
        logic signed [31:0] top_key;
        logic              top_valid;
        logic [6:0]        entry_count;
        logic [1:0]        status;
    } stim_row_t;

    typedef struct packed {
        logic signed [31:0] removed_key;
        logic signed [31:0] top_key;
        logic               top_valid;
        logic [6:0]         entry_count;
        logic [1:0]         status;
    } heap_result_t;

    logic clk;
    logic rst_n;
    bhpq_req_if req ();
    bhpq_rsp_if rsp ();
    bhpq_cfg_if cfg ();

    binary_heap_priority_queue #(.DEPTH(DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    // Predictor state
    logic signed [31:0] heap_keys [1:DEPTH];
    int                 heap_fill;
    logic               min_order;
    heap_result_t       pending_results [$];
    heap_result_t       fixed_results [$];
    logic               fixed_flags [$];
    int                 fail_count = 0;
    int                 idle_cycles = 0;
    bit                 hold_off;
    bit                 pressure_done;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // True when a belongs above b under the current order
    function automatic bit ranks_above(logic signed [31:0] a, logic signed [31:0] b);
        return min_order ? (a < b) : (a > b);
    endfunction

    // Apply one request to the predicted heap and return its result
    function automatic heap_result_t heap_apply(logic op, logic signed [31:0] key);
        heap_result_t r;
        int pos;
        int l;
        int pick;
        logic signed [31:0] t;
        r = '0;
        r.status = ST_DONE;
        if (op == OP_INSERT) begin
            if (heap_fill >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                heap_fill++;
                pos = heap_fill;
                while (pos > 1 && ranks_above(key, heap_keys[pos/2])) begin
                    heap_keys[pos] = heap_keys[pos/2];
                    pos = pos / 2;
                end
                heap_keys[pos] = key;
            end
        end else if (heap_fill == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.removed_key = heap_keys[1];
            heap_keys[1] = heap_keys[heap_fill];
            heap_fill--;
            pos = 1;
            while (2*pos <= heap_fill) begin
                l = 2*pos;
                if (!(ranks_above(heap_keys[l], heap_keys[pos]) ||
                      (l+1 <= heap_fill && ranks_above(heap_keys[l+1], heap_keys[pos]))))
                    break;
                pick = (l+1 <= heap_fill && !ranks_above(heap_keys[l], heap_keys[l+1]))
                       ? l+1 : l;
                t = heap_keys[pick];
                heap_keys[pick] = heap_keys[pos];
                heap_keys[pos] = t;
                pos = pick;
            end
        end
        r.top_valid   = (heap_fill != 0);
        r.top_key     = (heap_fill != 0) ? heap_keys[1] : '0;
        r.entry_count = heap_fill[6:0];
        return r;
    endfunction

    // Send one request, sometimes after a random gap, and record its expectation
    task automatic send_request(logic op, logic signed [31:0] key, bit fixed,
                                heap_result_t fixed_val);
        heap_result_t exp_r;
        if ($urandom_range(0, 3) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        req.valid     <= 1'b1;
        req.opcode    <= op;
        req.key_value <= key;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        exp_r = heap_apply(op, key);
        pending_results.push_back(exp_r);
        fixed_flags.push_back(fixed);
        fixed_results.push_back(fixed_val);
        @(negedge clk);
    endtask

    // Drop the request valid at the end of a burst
    task automatic end_burst();
        req.valid <= 1'b0;
    endtask

    // Wait for the block to drain before touching the mode register
    task automatic write_mode(logic mode);
        end_burst();
        while (pending_results.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= mode;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        min_order = mode;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic random_phase(int n, int insert_bias);
        logic op;
        logic signed [31:0] key;
        for (int i = 0; i < n; i++) begin
            op = ($urandom_range(0, 99) < insert_bias) ? OP_INSERT : OP_REMOVE;
            case ($urandom_range(0, 3))
                0: key = $urandom_range(0, 15) - 8;
                1: key = $urandom;
                2: key = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom)};
                default: key = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            endcase
            send_request(op, key, 1'b0, '0);
        end
    endtask

    // Receiver: stall pattern, plus one long hold-off
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= !hold_off && (($urandom_range(0, 7) > 2) || ($urandom_range(0, 1)));
    end

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        heap_result_t exp_r;
        heap_result_t fix_r;
        bit fixed;
        if (rst_n && rsp.valid && rsp.ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                fixed = fixed_flags.pop_front();
                fix_r = fixed_results.pop_front();
                if (fixed && fix_r != exp_r) begin
                    $error("table row disagrees with predictor");
                    fail_count++;
                end
                if (rsp.removed_key !== exp_r.removed_key) begin
                    $error("removed_key expected %0d actual %0d", exp_r.removed_key,
                           rsp.removed_key);
                    fail_count++;
                end
                if (rsp.top_key !== exp_r.top_key) begin
                    $error("top_key expected %0d actual %0d", exp_r.top_key, rsp.top_key);
                    fail_count++;
                end
                if (rsp.top_valid !== exp_r.top_valid) begin
                    $error("top_valid expected %0d actual %0d", exp_r.top_valid,
                           rsp.top_valid);
                    fail_count++;
                end
                if (rsp.entry_count !== exp_r.entry_count) begin
                    $error("entry_count expected %0d actual %0d", exp_r.entry_count,
                           rsp.entry_count);
                    fail_count++;
                end
                if (rsp.status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, rsp.status);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !hold_off) begin
            $display("binary_heap_priority_queue regression: fail");
            $finish;
        end
    end

    // Long receiver hold-off while requests keep coming
    initial
    begin
        hold_off = 1'b0;
        pressure_done = 1'b0;
        wait (pressure_done);
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        stim_row_t rows [$];
        heap_result_t fv;
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.opcode    = OP_INSERT;
        req.key_value = '0;
        cfg.valid     = 1'b0;
        cfg.data      = 1'b0;
        heap_fill     = 0;
        min_order     = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: opcode, key, fixed?, removed, top, valid, count, status
        rows = '{
            '{OP_REMOVE, 32'sd0, 1'b1, 32'sd0, 32'sd0, 1'b0, 7'd0, ST_EMPTY},
            '{OP_INSERT, 32'sh7fffffff, 1'b1, 32'sd0, 32'sh7fffffff, 1'b1, 7'd1, ST_DONE},
            '{OP_INSERT, 32'sh80000000, 1'b1, 32'sd0, 32'sh7fffffff, 1'b1, 7'd2, ST_DONE},
            '{OP_INSERT, 32'sd5, 1'b0, 0, 0, 0, 0, 0},
            '{OP_INSERT, 32'sd5, 1'b0, 0, 0, 0, 0, 0},
            '{OP_INSERT, -32'sd1, 1'b0, 0, 0, 0, 0, 0},
            '{OP_REMOVE, 32'shffffffff, 1'b0, 0, 0, 0, 0, 0},
            '{OP_REMOVE, 32'sd0, 1'b0, 0, 0, 0, 0, 0},
            '{OP_REMOVE, 32'sd0, 1'b0, 0, 0, 0, 0, 0},
            '{OP_REMOVE, 32'sd0, 1'b0, 0, 0, 0, 0, 0},
            '{OP_REMOVE, 32'sd0, 1'b1, 32'sh80000000, 32'sd0, 1'b0, 7'd0, ST_DONE},
            '{OP_REMOVE, 32'sd0, 1'b1, 32'sd0, 32'sd0, 1'b0, 7'd0, ST_EMPTY}
        };
        foreach (rows[i]) begin
            fv = {rows[i].removed_key, rows[i].top_key, rows[i].top_valid,
                  rows[i].entry_count, rows[i].status};
            send_request(rows[i].opcode, rows[i].key_value, rows[i].check_fixed, fv);
        end

        // Fill to capacity, then overflow; the receiver holds off meanwhile
        pressure_done = 1'b1;
        for (int i = 0; i < DEPTH; i++)
            send_request(OP_INSERT, $urandom, 1'b0, '0);
        fv = '0;
        fv.status = ST_FULL;
        send_request(OP_INSERT, 32'sd0, 1'b0, fv);
        random_phase(200, 45);

        // Min order, mode changed with entries held
        write_mode(1'b1);
        random_phase(300, 50);
        write_mode(1'b0);
        random_phase(250, 55);
        write_mode(1'b1);
        random_phase(250, 40);
        write_mode(1'b0);
        random_phase(80, 30);

        end_burst();
        while (pending_results.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        if (fail_count == 0)
            $display("binary_heap_priority_queue regression: pass");
        else
            $display("binary_heap_priority_queue regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
